### hdl/htsfp_pkg.sv
// ----------------------------------------------------------------------------
// htsfp_pkg: shared types and constants of the framed byte parser
// Result layout, buffer access bundle, register indexes and reset values.
// ----------------------------------------------------------------------------
package htsfp_pkg;

   localparam int BYTE_W = 8;
   localparam int IDX_W  = 6;
   localparam int CNT_W  = 32;

   typedef enum logic [0:0] {
      CSR_HEADER = 1'b0,
      CSR_TAIL   = 1'b1
   } csr_idx_type;

   localparam logic [BYTE_W-1:0] HEADER_RST = 8'hA5;
   localparam logic [BYTE_W-1:0] TAIL_RST   = 8'h5A;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_BAD = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [BYTE_W-1:0] payload_byte;
      logic [IDX_W-1:0]  payload_index;
      logic              last;
      logic [BYTE_W-1:0] computed_sum;
      logic [BYTE_W-1:0] received_sum;
      logic [CNT_W-1:0]  failure_total;
   } rsp_type;

   // payload buffer access: one write or one read address per cycle
   typedef struct packed {
      logic              we;
      logic [IDX_W-1:0]  addr;
      logic [BYTE_W-1:0] wdata;
   } buf_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header_byte;
      logic [BYTE_W-1:0] tail_byte;
   } cfg_type;

endpackage

### hdl/htsfp_chan_if.sv
// ----------------------------------------------------------------------------
// htsfp_chan_if: valid/ready channel
// One transfer per rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface htsfp_chan_if #(
   parameter type payload_type = logic [7:0]
) ();

   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

### hdl/htsfp_buf.sv
// ----------------------------------------------------------------------------
// htsfp_buf: payload buffer
// Single-port byte memory, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module htsfp_buf #(
   parameter int DEPTH = 32
) (
   input  logic                           clock,
   input  htsfp_pkg::buf_req_type         buf_req,
   output logic [htsfp_pkg::BYTE_W-1:0]   rd_data
);
   import htsfp_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (buf_req.we) begin
         mem[buf_req.addr[AW-1:0]] <= buf_req.wdata;
      end
      rd_data_ff <= mem[buf_req.addr[AW-1:0]];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/htsfp_ctrl.sv
// ----------------------------------------------------------------------------
// htsfp_ctrl: frame sequencer
// Header/payload/checksum/tail parsing, buffer sweep through one 8-bit
// accumulator, compare, and payload replay or mismatch report through an output register.
// ----------------------------------------------------------------------------
module htsfp_ctrl #(
   parameter int PAYLOAD_LEN = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  htsfp_pkg::cfg_type             cfg,
   htsfp_chan_if.sink                     req_chan,
   htsfp_chan_if.source                   rsp_chan,
   output htsfp_pkg::buf_req_type         buf_req,
   input  logic [htsfp_pkg::BYTE_W-1:0]   rd_data
);
   import htsfp_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_LEN - 1);

   typedef enum logic [9:0] {
      S_HEAD   = 10'b00_0000_0001,
      S_DATA   = 10'b00_0000_0010,
      S_CHK    = 10'b00_0000_0100,
      S_TAIL   = 10'b00_0000_1000,
      S_SUM    = 10'b00_0001_0000,
      S_SUMEND = 10'b00_0010_0000,
      S_CMP    = 10'b00_0100_0000,
      S_ERR    = 10'b00_1000_0000,
      S_ERD    = 10'b01_0000_0000,
      S_EWR    = 10'b10_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] chk_ff, chk_in;
   logic [BYTE_W-1:0] acc_ff, acc_in;
   logic              add_en_ff, add_en_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              rx_ready;
   logic              take;
   logic              out_free;
   logic [BYTE_W-1:0] rx;

   assign rx       = req_chan.data.rx_byte;
   assign rx_ready = (state_ff == S_HEAD) || (state_ff == S_DATA) ||
                     (state_ff == S_CHK)  || (state_ff == S_TAIL);
   assign take     = req_chan.valid && rx_ready;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      chk_in        = chk_ff;
      acc_in        = acc_ff;
      cnt_in        = cnt_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      add_en_in     = (state_ff == S_SUM);
      buf_req.we    = 1'b0;
      buf_req.addr  = pos_ff;
      buf_req.wdata = rx;

      unique case (state_ff)
         S_HEAD: begin
            if (take && (rx == cfg.header_byte)) begin
               state_in = S_DATA;
               pos_in   = '0;
            end
         end
         S_DATA: begin
            if (take) begin
               buf_req.we = 1'b1;
               pos_in     = pos_ff + 1'b1;
               if (pos_ff == LAST_IDX) begin
                  state_in = S_CHK;
               end
            end
         end
         S_CHK: begin
            if (take) begin
               chk_in   = rx;
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (take) begin
               pos_in   = '0;
               acc_in   = '0;
               state_in = (rx == cfg.tail_byte) ? S_SUM : S_HEAD;
            end
         end
         S_SUM: begin
            // address runs ahead of the accumulator, which adds each read byte in the next cycle
            if (pos_ff == LAST_IDX) begin
               pos_in   = '0;
               state_in = S_SUMEND;
            end else begin
               pos_in = pos_ff + 1'b1;
            end
         end
         S_SUMEND: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            state_in = (acc_ff == chk_ff) ? S_ERD : S_ERR;
         end
         S_ERR: begin
            if (out_free) begin
               out_in.status        = STATUS_BAD;
               out_in.payload_byte  = '0;
               out_in.payload_index = '0;
               out_in.last          = 1'b1;
               out_in.computed_sum  = acc_ff;
               out_in.received_sum  = chk_ff;
               out_in.failure_total = cnt_ff + 1'b1;
               cnt_in               = cnt_ff + 1'b1;
               out_valid_in         = 1'b1;
               state_in             = S_HEAD;
            end
         end
         S_ERD: begin
            state_in = S_EWR;
         end
         S_EWR: begin
            if (out_free) begin
               out_in.status        = STATUS_OK;
               out_in.payload_byte  = rd_data;
               out_in.payload_index = pos_ff;
               out_in.last          = (pos_ff == LAST_IDX);
               out_in.computed_sum  = acc_ff;
               out_in.received_sum  = chk_ff;
               out_in.failure_total = cnt_ff;
               out_valid_in         = 1'b1;
               if (pos_ff == LAST_IDX) begin
                  pos_in   = '0;
                  state_in = S_HEAD;
               end else begin
                  pos_in   = pos_ff + 1'b1;
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_HEAD;
         end
      endcase

      if (add_en_ff) begin
         acc_in = acc_ff + rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_HEAD;
         pos_ff       <= '0;
         chk_ff       <= '0;
         acc_ff       <= '0;
         add_en_ff    <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         chk_ff       <= chk_in;
         acc_ff       <= acc_in;
         add_en_ff    <= add_en_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign req_chan.ready = rx_ready;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.data  = out_ff;

endmodule

### hdl/header_tail_sum8_frame_parser.sv
// Flow: a matching tail starts a checksum sweep of the buffer and a compare,
//   then each result is read from the buffer and loaded into the output register.
// Throughput: one byte per cycle while parsing; not ready during the sweep,
//   the compare and the replay or mismatch report, including result stalls.
// Reset: synchronous, active high; registers to 0xA5 / 0x5A, header search,
//   failure count zero. Buffer contents are not cleared.
// ----------------------------------------------------------------------------
// header_tail_sum8_frame_parser: framed byte parser with 8-bit checksum
// Waits for a header, buffers the payload, checks the tail and the
// modulo-256 sum, then replays the payload or reports a mismatch.
// ----------------------------------------------------------------------------
module header_tail_sum8_frame_parser #(
   parameter int PAYLOAD_LEN = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  htsfp_pkg::csr_idx_type         csr_index,
   input  logic [htsfp_pkg::BYTE_W-1:0]   csr_wdata,
   htsfp_chan_if.sink                     req_chan,
   htsfp_chan_if.source                   rsp_chan
);
   import htsfp_pkg::*;

   // Configuration registers. The user must write them only while the parser is idle;
   // the block does not enforce this, and the sequencer samples them live without a shadow copy.
   cfg_type cfg_ff, cfg_in;

   // Buffer access bundle: the sequencer writes during the payload phase, then sweeps
   // the same port for the checksum and, on a match, again for the replay.
   buf_req_type       buf_req;
   logic [BYTE_W-1:0] rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HEADER: cfg_in.header_byte = csr_wdata;
            CSR_TAIL:   cfg_in.tail_byte   = csr_wdata;
            default:    cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte <= HEADER_RST;
         cfg_ff.tail_byte   <= TAIL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Payload store: one byte per slot, registered read.
   htsfp_buf #(
      .DEPTH (PAYLOAD_LEN)
   ) u_buf (
      .clock   (clock),
      .buf_req (buf_req),
      .rd_data (rd_data)
   );

   // Sequencer: parsing, single 8-bit accumulator, compare, and the
   // output register that decouples the result side from the input side.
   htsfp_ctrl #(
      .PAYLOAD_LEN (PAYLOAD_LEN)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .buf_req  (buf_req),
      .rd_data  (rd_data)
   );

endmodule
